### src/oboe_pkg.sv
package oboe_pkg;

    // Character codes used by the escape rules
    localparam logic [7:0] BACKSLASH  = 8'h5C;
    localparam logic [7:0] QUOTE      = 8'h22;
    localparam logic [7:0] PRINT_LO   = 8'h20;
    localparam logic [7:0] PRINT_HI   = 8'h7E;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;

    // Position of a beat within the expansion of one input byte (up to four)
    typedef logic [1:0] beat_idx_t;

    // One output beat as produced by the expander
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } beat_t;

endpackage

### src/oboe_expand.sv
module oboe_expand
(
    input  logic [7:0]          raw,
    input  oboe_pkg::beat_idx_t idx,
    output oboe_pkg::beat_t     beat
);

    logic is_pair;
    logic is_octal;

    // Classify the byte: paired escape, octal escape or pass-through
    assign is_pair  = (raw == oboe_pkg::BACKSLASH) || (raw == oboe_pkg::QUOTE);
    assign is_octal = (raw < oboe_pkg::PRINT_LO) || (raw > oboe_pkg::PRINT_HI);

    // Select the byte at the requested position of the expansion
    always_comb
    begin
        beat.data = oboe_pkg::BACKSLASH;
        beat.last = 1'b0;
        case (idx)
            2'd0:
            begin
                if (!is_pair && !is_octal)
                begin
                    beat.data = raw;
                    beat.last = 1'b1;
                end
            end
            2'd1:
            begin
                if (is_octal)
                begin
                    beat.data = oboe_pkg::DIGIT_ZERO | {6'd0, raw[7:6]};
                end
                else
                begin
                    beat.data = raw;
                    beat.last = 1'b1;
                end
            end
            2'd2:
            begin
                beat.data = oboe_pkg::DIGIT_ZERO | {5'd0, raw[5:3]};
            end
            2'd3:
            begin
                beat.data = oboe_pkg::DIGIT_ZERO | {5'd0, raw[2:0]};
                beat.last = 1'b1;
            end
            default:
            begin
                beat.data = oboe_pkg::BACKSLASH;
                beat.last = 1'b0;
            end
        endcase
    end

endmodule

### src/octal_backslash_escape_encoder.sv
// An accepted input byte passes through the hold register and then the output
// register before its first output beat appears. Each input byte gives 1, 2 or 4 beats
// (one output beat per cycle from the output register while out_stall is low); a new byte
// is taken in the cycle its last beat moves into the output register.
// Reset (rst_n low, asynchronous) empties the hold and output registers.
module octal_backslash_escape_encoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_last
);

    logic                hold_valid_reg;
    logic [7:0]          hold_byte_reg;
    oboe_pkg::beat_idx_t hold_idx_reg;
    logic                out_valid_reg;
    logic [7:0]          out_byte_reg;
    logic                run_last_reg;

    oboe_pkg::beat_t     beat;
    logic                load_out;
    logic                in_take;

    // Work out the beat at the current position of the held byte
    oboe_expand u_expand
    (
        .raw  (hold_byte_reg),
        .idx  (hold_idx_reg),
        .beat (beat)
    );

    // Advance when the output register is empty or being drained
    assign load_out = hold_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = hold_valid_reg && !(load_out && beat.last);
    assign in_take  = in_valid && !in_stall;

    // Hold the byte being expanded and its beat position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            hold_idx_reg   <= '0;
        end
        else if (in_take)
        begin
            hold_valid_reg <= 1'b1;
            hold_idx_reg   <= '0;
        end
        else if (load_out)
        begin
            if (beat.last)
            begin
                hold_valid_reg <= 1'b0;
            end
            hold_idx_reg <= hold_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            hold_byte_reg <= in_byte;
        end
    end

    // Output register: load the next beat, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_byte_reg <= beat.data;
            run_last_reg <= beat.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;

endmodule

### src/oboe_check.sv
module oboe_check
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] in_byte,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       run_last
);

    // A stalled input beat keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_byte))
    else $error("stalled input beat changed");

    // A stalled output beat keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(run_last))
    else $error("stalled output beat changed");

    // A run that is not finished continues in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !run_last |=> out_valid)
    else $error("gap inside an escape run");

    // Every beat before the last of a run is a backslash or an octal digit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_last |-> (out_byte == oboe_pkg::BACKSLASH)
            || (out_byte[7:3] == oboe_pkg::DIGIT_ZERO[7:3]))
    else $error("unexpected byte inside an escape run");

    // Reset leaves no output beat pending
    assert property (@(posedge clk) !rst_n |-> !out_valid)
    else $error("output valid during reset");

endmodule

bind octal_backslash_escape_encoder oboe_check u_oboe_check
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .run_last  (run_last)
);

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned RANDOM_BYTES = 360;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 20;

    // Expected escape expansions of accepted bytes, oldest first
    class escape_expansions;
        oboe_pkg::beat_t pending_beats[$];
        int unsigned     errors;

        function void add_beat(logic [7:0] data, logic last);
            oboe_pkg::beat_t bt;
            bt.data = data;
            bt.last = last;
            pending_beats.push_back(bt);
        endfunction

        // Expand one accepted byte into the beats it must produce
        function void note_byte(logic [7:0] b);
            if (b == oboe_pkg::BACKSLASH || b == oboe_pkg::QUOTE)
            begin
                add_beat(oboe_pkg::BACKSLASH, 1'b0);
                add_beat(b, 1'b1);
            end
            else if (b < oboe_pkg::PRINT_LO || b > oboe_pkg::PRINT_HI)
            begin
                add_beat(oboe_pkg::BACKSLASH, 1'b0);
                add_beat(oboe_pkg::DIGIT_ZERO + {6'd0, b[7:6]}, 1'b0);
                add_beat(oboe_pkg::DIGIT_ZERO + {5'd0, b[5:3]}, 1'b0);
                add_beat(oboe_pkg::DIGIT_ZERO + {5'd0, b[2:0]}, 1'b1);
            end
            else
            begin
                add_beat(b, 1'b1);
            end
        endfunction

        // Compare one output beat with the oldest expectation
        function void check_beat(logic [7:0] data, logic last);
            oboe_pkg::beat_t want;
            if (pending_beats.size() == 0)
            begin
                $error("out_byte %02h arrived with nothing expected", data);
                errors++;
                return;
            end
            want = pending_beats.pop_front();
            if (data !== want.data)
            begin
                $error("out_byte: expected %02h, got %02h", want.data, data);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("run_last: expected %0b, got %0b", want.last, last);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return pending_beats.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       run_last;

    escape_expansions escapes = new();

    int unsigned bytes_taken  = 0;
    int unsigned cycle_count  = 0;
    int unsigned burst_left   = 0;
    bit          holding_off  = 1'b0;
    bit          hold_done    = 1'b0;

    octal_backslash_escape_encoder DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_last  (run_last)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Watch both channels: note accepted bytes, check accepted beats
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            escapes.note_byte(in_byte);
            bytes_taken++;
        end
        if (rst_n && out_valid && !out_stall)
            escapes.check_beat(out_byte, run_last);
    end

    // Give up once the cycle budget is spent
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("octal_backslash_escape_encoder test failed");
        $finish;
    end

    // Stall the output in segments of varying density, with one long hold-off
    initial
    begin
        int unsigned seg_len;
        int unsigned pct;
        out_stall = 1'b0;
        forever
        begin
            if (!hold_done && bytes_taken >= 200)
            begin
                hold_done   = 1'b1;
                holding_off = 1'b1;
                seg_len     = 80;
                pct         = 100;
            end
            else
            begin
                seg_len = $urandom_range(5, 40);
                case ($urandom_range(3))
                    0: pct = 0;
                    1: pct = 20;
                    2: pct = 50;
                    default: pct = 75;
                endcase
            end
            repeat (seg_len)
            begin
                @(posedge clk);
                out_stall <= ($urandom_range(99) < pct);
            end
            holding_off = 1'b0;
        end
    end

    // Offer one byte, in bursts with random gaps; hold it until taken
    task automatic offer_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
            if (!holding_off && $urandom_range(3) != 0)
            begin
                gap = $urandom_range(1, 6);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] directed_bytes[$];
        logic [7:0] b;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_byte  = 8'h00;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes, both printable edges, backslash and quote, octal corners
        directed_bytes = '{8'h00, 8'hFF, 8'h1F, 8'h20, 8'h7E, 8'h7F, 8'h80,
                           8'h5C, 8'h5C, 8'h22, 8'h22, 8'h41, 8'h0A, 8'hC9,
                           8'h3F, 8'h7A, 8'h5B, 8'h21, 8'h23, 8'h5D, 8'h30};
        foreach (directed_bytes[i])
            offer_byte(directed_bytes[i]);

        // Random bytes from each class, with backslash and quote weighted heavily
        repeat (RANDOM_BYTES)
        begin
            case ($urandom_range(9))
                0, 1, 2: b = 8'($urandom_range(8'h20, 8'h7E));
                3:       b = oboe_pkg::BACKSLASH;
                4:       b = oboe_pkg::QUOTE;
                5:       b = 8'($urandom_range(8'h00, 8'h1F));
                6:       b = 8'($urandom_range(8'h7F, 8'hFF));
                default: b = 8'($urandom_range(255));
            endcase
            offer_byte(b);
        end
        in_valid <= 1'b0;

        // Drain the expected beats, then watch for strays
        while (escapes.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (escapes.errors == 0)
            $display("octal_backslash_escape_encoder test passed");
        else
            $display("octal_backslash_escape_encoder test failed");
        $finish;
    end

endmodule
